### src/utf8d_pkg.sv
// types, constants and lead-byte helpers shared by the utf-8 stream decoder
package utf8d_pkg;

    localparam int CODE_W = 31;
    localparam int LEN_W  = 3;

    localparam logic [7:0] LEAD6_MASK = 8'b1111_1100;
    localparam logic [7:0] LEAD5_MASK = 8'b1111_1000;
    localparam logic [7:0] LEAD4_MASK = 8'b1111_0000;
    localparam logic [7:0] LEAD3_MASK = 8'b1110_0000;
    localparam logic [7:0] LEAD2_MASK = 8'hC0;
    localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

    localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic [LEN_W-1:0]  sequence_length;
        logic              truncated;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } step_t;

    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        priority if ((b & LEAD6_MASK) == LEAD6_MASK) len = 3'd6;
        else if ((b & LEAD5_MASK) == LEAD5_MASK) len = 3'd5;
        else if ((b & LEAD4_MASK) == LEAD4_MASK) len = 3'd4;
        else if ((b & LEAD3_MASK) == LEAD3_MASK) len = 3'd3;
        else if ((b & LEAD2_MASK) == LEAD2_MASK) len = 3'd2;
        else len = LEN_ONE;
        return len;
    endfunction

endpackage

### src/utf8d_decode.sv
// sequence state and per-byte decode step
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  fire,
    input  item_t item,
    output step_t step
);

    logic [LEN_W-1:0]  pending_reg, pending_next;
    logic [LEN_W-1:0]  announced_reg, announced_next;
    logic [CODE_W-1:0] partial_reg, partial_next;

    always_comb begin
        logic [LEN_W-1:0]  len;
        logic [7:0]        lead_mask;
        logic [CODE_W-1:0] lead_bits;
        logic [CODE_W-1:0] shifted;
        logic [LEN_W-1:0]  pend_dec;

        len       = lead_length(item.text_byte);
        lead_mask = PAYLOAD_MASK >> (len - LEN_ONE);
        lead_bits = {{(CODE_W-8){1'b0}}, item.text_byte & lead_mask};
        shifted   = {partial_reg[CODE_W-7:0], item.text_byte[5:0]};
        pend_dec  = pending_reg - LEN_ONE;

        step           = '0;
        pending_next   = '0;
        announced_next = '0;
        partial_next   = '0;

        if (pending_reg == '0) begin
            if (len == LEN_ONE) begin
                step.emit = 1'b1;
                step.res.code_point = item.text_byte[7]
                    ? {{(CODE_W-6){1'b0}}, item.text_byte[5:0]}
                    : {{(CODE_W-8){1'b0}}, item.text_byte};
                step.res.sequence_length = LEN_ONE;
                step.res.last = item.end_of_text;
            end else if (item.end_of_text) begin
                step.emit = 1'b1;
                step.res.code_point = lead_bits;
                step.res.sequence_length = len;
                step.res.truncated = 1'b1;
                step.res.last = 1'b1;
            end else begin
                pending_next   = len - LEN_ONE;
                announced_next = len;
                partial_next   = lead_bits;
            end
        end else begin
            if (pend_dec == '0) begin
                step.emit = 1'b1;
                step.res.code_point = shifted;
                step.res.sequence_length = announced_reg;
                step.res.last = item.end_of_text;
            end else if (item.end_of_text) begin
                step.emit = 1'b1;
                step.res.code_point = shifted;
                step.res.sequence_length = announced_reg;
                step.res.truncated = 1'b1;
                step.res.last = 1'b1;
            end else begin
                pending_next   = pend_dec;
                announced_next = announced_reg;
                partial_next   = shifted;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= '0;
            announced_reg <= '0;
            partial_reg   <= '0;
        end else if (fire) begin
            pending_reg   <= pending_next;
            announced_reg <= announced_next;
            partial_reg   <= partial_next;
        end
    end

endmodule

### src/utf8_stream_decoder.sv
// Decodes a byte stream under the original six-byte UTF-8 rule, one code point per sequence.
// Takes one byte per cycle with no gaps; a byte is held in the input register and
// its code point, if it ends a sequence, is then written into the result register.
// Only a stalled result register with a new result waiting stops intake. The decode step
// between the two registers is a lead-length priority match and a 6-bit shift-and-or.
// A text that ends mid-sequence yields the bits gathered so far with the truncated flag set.
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // code_point[30:0], sequence_length[33:31], zero pad
    output logic [0:0]  m_tuser,   // truncated
    output logic        m_tlast    // last
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    step_t   step;
    logic    out_free;
    logic    stage_go;

    utf8d_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (stage_go),
        .item    (in_item_reg),
        .step    (step)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign stage_go = in_valid_reg && (out_free || !step.emit);
    assign s_tready = !in_valid_reg || stage_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.text_byte   <= s_tdata;
            in_item_reg.end_of_text <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stage_go && step.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_go && step.emit) begin
            out_res_reg <= step.res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.sequence_length, out_res_reg.code_point};
    assign m_tuser  = out_res_reg.truncated;
    assign m_tlast  = out_res_reg.last;

    // a truncated result always closes the text
    assert property (@(posedge aclk) disable iff (!aresetn)
        stage_go && step.emit && step.res.truncated |-> step.res.last)
        else $error("truncated result without last");

    // a one-byte sequence can never be cut off
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:31] == LEN_ONE |-> !m_tuser[0])
        else $error("one-byte sequence flagged truncated");

    // a held item stays in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !stage_go |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled item lost");

    // results always carry a nonzero length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33:31] != '0)
        else $error("result with zero length");

endmodule

### tb/sv/utf8_stream_decoder_tb.sv
// self-checking testbench for utf8_stream_decoder with a byte-stream driver and a code-point monitor
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;
    import utf8d_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1650;
    localparam int IDLE_PCT     = 17;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    item_t   text_bytes[$];
    result_t pending_points[$];

    logic [LEN_W-1:0]  need_cnt = '0;
    logic [CODE_W-1:0] code_acc = '0;
    logic [LEN_W-1:0]  seq_len  = '0;

    int  text_total  = 0;
    int  bytes_taken = 0;
    int  mismatches  = 0;
    int  cycle_cnt   = 0;
    logic calm;

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // no idling on either side through this stretch
    assign calm = (bytes_taken >= 600) && (bytes_taken < 900);

    task automatic queue_byte(input logic [7:0] b, input logic eot);
        item_t it;
        it.text_byte   = b;
        it.end_of_text = eot;
        text_bytes.insert(text_bytes.size(), it);
        text_total++;
    endtask

    task automatic clear_decode();
        need_cnt = '0;
        code_acc = '0;
        seq_len  = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [LEN_W-1:0] len;
        result_t r;
        logic done;
        done = 1'b0;
        r    = '0;
        if (need_cnt == 0) begin
            if ((b & LEAD6_MASK) == LEAD6_MASK) len = 3'd6;
            else if ((b & LEAD5_MASK) == LEAD5_MASK) len = 3'd5;
            else if ((b & LEAD4_MASK) == LEAD4_MASK) len = 3'd4;
            else if ((b & LEAD3_MASK) == LEAD3_MASK) len = 3'd3;
            else if ((b & LEAD2_MASK) == LEAD2_MASK) len = 3'd2;
            else len = LEN_ONE;
            if (len == LEN_ONE) begin
                // stray continuation keeps only its payload bits
                r.code_point      = b[7] ? {25'd0, b[5:0]} : {24'd0, b[6:0]};
                r.sequence_length = LEN_ONE;
                r.truncated       = 1'b0;
                r.last            = eot;
                done = 1'b1;
                clear_decode();
            end else begin
                code_acc = {23'd0, b & (PAYLOAD_MASK >> (len - 3'd1))};
                need_cnt = len - 3'd1;
                seq_len  = len;
                if (eot) begin
                    r.code_point      = code_acc;
                    r.sequence_length = len;
                    r.truncated       = 1'b1;
                    r.last            = 1'b1;
                    done = 1'b1;
                    clear_decode();
                end
            end
        end else begin
            code_acc = {code_acc[CODE_W-7:0], b[5:0]};
            need_cnt = need_cnt - 3'd1;
            if (need_cnt == 0 || eot) begin
                r.code_point      = code_acc;
                r.sequence_length = seq_len;
                r.truncated       = (need_cnt != 0);
                r.last            = eot;
                done = 1'b1;
                clear_decode();
            end
        end
        if (done) pending_points.insert(pending_points.size(), r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0h, want %0h (byte %0d)", what, got, want, bytes_taken);
        mismatches++;
    endtask

    always @(posedge aclk) begin : byte_feed
        item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                decode_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (text_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = text_bytes[0];
                text_bytes.delete(0);
                s_tdata  <= nxt.text_byte;
                s_tlast  <= nxt.end_of_text;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : point_check
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            if (m_tvalid && m_tready) begin
                if (pending_points.size() == 0) begin
                    report_mismatch("unexpected item", {1'b0, m_tdata[30:0]}, 32'd0);
                end else begin
                    want = pending_points[0];
                    pending_points.delete(0);
                    if (m_tdata[30:0] !== want.code_point)
                        report_mismatch("code_point", {1'b0, m_tdata[30:0]},
                                        {1'b0, want.code_point});
                    if (m_tdata[33:31] !== want.sequence_length)
                        report_mismatch("sequence_length", {29'd0, m_tdata[33:31]},
                                        {29'd0, want.sequence_length});
                    if (m_tuser[0] !== want.truncated)
                        report_mismatch("truncated", {31'd0, m_tuser[0]},
                                        {31'd0, want.truncated});
                    if (m_tlast !== want.last)
                        report_mismatch("last", {31'd0, m_tlast}, {31'd0, want.last});
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("utf8_stream_decoder_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        int mode;
        int len;
        int cut;
        int k;
        logic [7:0] b;

        // ascii extremes and stray continuations
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hBF, 1'b1);
        // following byte that looks like a lead is taken unchecked
        queue_byte(8'hDF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hE0, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hBF, 1'b0);
        // four-byte sequence cut off by end of text
        queue_byte(8'hF7, 1'b0);
        queue_byte(8'hBF, 1'b1);
        // 0xfe lead as a six-byte lead
        queue_byte(8'hFE, 1'b0);
        for (k = 0; k < 5; k++) queue_byte(8'hBF, 1'b0);
        // lead alone at end of text
        queue_byte(8'hFC, 1'b1);
        // five-byte sequence ending the text
        queue_byte(8'hFB, 1'b0);
        for (k = 0; k < 3; k++) queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b1);
        // 0xff lead cut off at once
        queue_byte(8'hFF, 1'b1);

        while (text_total < 24 + RANDOM_BYTES) begin
            mode = $urandom_range(0, 99);
            if (mode < 70) begin
                len = $urandom_range(1, 6);
                case (len)
                    1: b = 8'($urandom_range(0, 127));
                    2: b = 8'hC0 | 8'($urandom_range(0, 31));
                    3: b = 8'hE0 | 8'($urandom_range(0, 15));
                    4: b = 8'hF0 | 8'($urandom_range(0, 7));
                    5: b = 8'hF8 | 8'($urandom_range(0, 3));
                    default: b = 8'hFC | 8'($urandom_range(0, 3));
                endcase
                if (len == 1) begin
                    queue_byte(b, $urandom_range(0, 99) < 8);
                end else begin
                    queue_byte(b, 1'b0);
                    for (k = 1; k < len; k++) begin
                        b = 8'h80 | 8'($urandom_range(0, 63));
                        queue_byte(b, (k == len - 1) && ($urandom_range(0, 99) < 8));
                    end
                end
            end else if (mode < 88) begin
                b = 8'($urandom_range(0, 255));
                queue_byte(b, $urandom_range(0, 99) < 3);
            end else begin
                // sequence broken off by end of text
                len = $urandom_range(2, 6);
                cut = $urandom_range(0, len - 2);
                case (len)
                    2: b = 8'hC0 | 8'($urandom_range(0, 31));
                    3: b = 8'hE0 | 8'($urandom_range(0, 15));
                    4: b = 8'hF0 | 8'($urandom_range(0, 7));
                    5: b = 8'hF8 | 8'($urandom_range(0, 3));
                    default: b = 8'hFC | 8'($urandom_range(0, 3));
                endcase
                queue_byte(b, cut == 0);
                for (k = 1; k <= cut; k++) begin
                    b = 8'($urandom_range(0, 255));
                    queue_byte(b, k == cut);
                end
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_taken < text_total) @(negedge aclk);
        while (pending_points.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0) begin
            $display("utf8_stream_decoder_tb passed");
        end else begin
            $display("utf8_stream_decoder_tb failed");
        end
        $finish;
    end

endmodule
